@@ design/gs3_pkg.sv @@
`default_nettype none
package gs3_pkg;

    // fixed field widths
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 16;
    localparam int COL_OUT_W = 10;
    localparam int CFG_FW_W  = 11;
    localparam int CFG_FH_W  = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // kernel weights sum to 16
    localparam int KERNEL_SHIFT = 4;
    localparam int SUM_W        = PIX_W + KERNEL_SHIFT;

    // smallest frame dimension that has an interior
    localparam int MIN_DIM = 3;

    localparam logic [CFG_FW_W-1:0] FRAME_WIDTH_RESET  = 11'd64;
    localparam logic [CFG_FH_W-1:0] FRAME_HEIGHT_RESET = 16'd64;

    // register map, word index
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    // result slots an item can produce, in emission order
    localparam int EMIT_CTR  = 0;  // smoothed pixel one row up, one column left
    localparam int EMIT_EDGE = 1;  // right border pixel one row up
    localparam int EMIT_OWN  = 2;  // top or bottom row pixel itself

    typedef struct packed {
        logic                 restart;
        logic [CFG_FH_W-1:0]  height;
    } t_cfg_ctl;

    typedef struct packed {
        logic [PIX_W-1:0]     smooth;
        logic [PIX_W-1:0]     mid;
        logic [PIX_W-1:0]     pix;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [2:0]           emit;
    } t_res_item;

endpackage
`default_nettype wire

@@ design/gaussian_3x3_smooth_core.sv @@
`default_nettype none
// Streaming 3x3 Gaussian smoothing (1-2-1 / 2-4-2 / 1-2-1, divided by 16 with
// truncation) of a grayscale frame sent one 8-bit pixel per item in raster
// order. Every pixel comes out once, tagged with row and column; border rows
// and columns pass through unchanged. Interior pixel (r-1,c-1) is emitted when
// (r,c) arrives, so output trails input by one row and one column. The block
// takes one pixel per clock while the output buffer keeps up: the pixel enters
// a register stage where the two line stores (single-port-read RAMs, one read
// per pixel) return the pixels above it, and its results are then loaded into
// an output buffer once that buffer is free or is handing out its last result.
// The output drains one result per clock while i_ready is high, so a pixel that
// yields several results can hold the input while they drain when the output
// side is ready: the last pixel of each row from row 2 on and every pixel past
// column 0 of the last row yield two, and the last pixel of the frame three.
// No clearing pass after reset is needed. Writing frame_width (0x0) or
// frame_height (0x4) restarts the frame at row 0, column 0; write only while
// the block is idle.
module gaussian_3x3_smooth_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [gs3_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [gs3_pkg::PIX_W-1:0]     o_pixel_out,
    output logic      [gs3_pkg::ROW_W-1:0]     o_out_row,
    output logic      [gs3_pkg::COL_OUT_W-1:0] o_out_col,
    output logic                               o_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [gs3_pkg::APB_AW-1:0]    paddr,
    input  wire logic [gs3_pkg::APB_DW-1:0]    pwdata,
    output logic      [gs3_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);
    import gs3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);

    logic [EW-1:0]    width;
    t_cfg_ctl         ctl;

    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    r_col;
    logic [CW:0]      col_inc;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_pix;
    logic [ROW_W-1:0] r_s1_row;
    logic [CW-1:0]    r_s1_col;

    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] smooth;
    logic [2:0]       emit;
    logic             accept;
    logic             s1_adv;
    logic             ob_free;
    t_res_item        item;

    // configuration registers
    gs3_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_width (width),
        .o_ctl   (ctl)
    );

    assign accept  = i_valid & o_ready;
    assign o_ready = ~r_s1_valid | s1_adv;

    // raster position of the next arriving pixel
    assign col_inc = (CW+1)'(r_col) + (CW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (ctl.restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (col_inc >= (CW+1)'(width)) begin
                r_col <= '0;
                r_row <= (r_row == ctl.height - ROW_W'(1)) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= col_inc[CW-1:0];
            end
        end
    end

    // input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= i_pixel_in;
            r_s1_row <= r_row;
            r_s1_col <= r_col;
        end
    end

    // line stores: read on accept, shift down the column on advance
    gs3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pix),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (mid)
    );

    gs3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev2 (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (mid),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (top)
    );

    // window and kernel
    gs3_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (s1_adv),
        .i_col_one (r_s1_col == CW'(1)),
        .i_top     (top),
        .i_mid     (mid),
        .i_pix     (r_s1_pix),
        .o_smooth  (smooth)
    );

    // which results this item causes
    always_comb begin
        emit[EMIT_CTR]  = (r_s1_row >= ROW_W'(2)) & (r_s1_col != '0);
        emit[EMIT_EDGE] = emit[EMIT_CTR] &
                          ((CW+1)'(r_s1_col) == (CW+1)'(width) - (CW+1)'(1));
        emit[EMIT_OWN]  = (r_s1_row == '0) | (r_s1_row == ctl.height - ROW_W'(1));
    end

    // items without results pass straight through
    assign s1_adv = r_s1_valid & (~(|emit) | ob_free);

    always_comb begin
        item.smooth = smooth;
        item.mid    = mid;
        item.pix    = r_s1_pix;
        item.row    = r_s1_row;
        item.col    = COL_OUT_W'(r_s1_col);
        item.emit   = emit;
    end

    // result buffer
    gs3_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s1_adv & (|emit)),
        .i_item      (item),
        .o_free      (ob_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_out (o_pixel_out),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

@@ design/gs3_ram.sv @@
`default_nettype none
module gs3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ design/gs3_cfg.sv @@
`default_nettype none
module gs3_cfg #(
    parameter int MAX_WIDTH = 1024,
    localparam int EW       = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [gs3_pkg::APB_AW-1:0]   paddr,
    input  wire logic [gs3_pkg::APB_DW-1:0]   pwdata,
    output logic      [gs3_pkg::APB_DW-1:0]   prdata,
    output logic                              pready,
    output logic      [EW-1:0]                o_width,
    output gs3_pkg::t_cfg_ctl                 o_ctl
);
    import gs3_pkg::*;

    logic [CFG_FW_W-1:0] r_frame_width;
    logic [CFG_FH_W-1:0] r_frame_height;
    logic                wr;
    t_reg_idx            idx;

    assign idx    = t_reg_idx'(paddr[2]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
        end else if (wr) begin
            case (idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_FH_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // width clamped to the line store range
    always_comb begin
        if (r_frame_width < CFG_FW_W'(MIN_DIM)) begin
            o_width = EW'(MIN_DIM);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            o_width = EW'(MAX_WIDTH);
        end else begin
            o_width = EW'(r_frame_width);
        end
    end

    // height clamped from below, any write restarts the frame
    always_comb begin
        o_ctl.restart = wr;
        o_ctl.height  = (r_frame_height < CFG_FH_W'(MIN_DIM)) ? CFG_FH_W'(MIN_DIM)
                                                             : r_frame_height;
    end

endmodule
`default_nettype wire

@@ design/gs3_window.sv @@
`default_nettype none
module gs3_window (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_col_one,
    input  wire logic [gs3_pkg::PIX_W-1:0]  i_top,
    input  wire logic [gs3_pkg::PIX_W-1:0]  i_mid,
    input  wire logic [gs3_pkg::PIX_W-1:0]  i_pix,
    output logic      [gs3_pkg::PIX_W-1:0]  o_smooth
);
    import gs3_pkg::*;

    // columns c-1 (0..2) and c-2 (3..5), top/mid/bottom
    logic [PIX_W-1:0] r_win [6];
    logic [SUM_W-1:0] s_edges;
    logic [SUM_W-1:0] s_corners;
    logic [SUM_W-1:0] s_total;

    // shift the window one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_adv) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= i_top;
            r_win[1] <= i_mid;
            r_win[2] <= i_pix;
        end
    end

    // 1-2-1 / 2-4-2 / 1-2-1 around the window center
    always_comb begin
        s_edges   = SUM_W'(r_win[4]) + SUM_W'(i_mid) + SUM_W'(r_win[0]) + SUM_W'(r_win[2]);
        s_corners = SUM_W'(r_win[3]) + SUM_W'(r_win[5]) + SUM_W'(i_top) + SUM_W'(i_pix);
        s_total   = (SUM_W'(r_win[1]) << 2) + (s_edges << 1) + s_corners;
    end

    // left border column passes the center through
    assign o_smooth = i_col_one ? r_win[1] : s_total[KERNEL_SHIFT +: PIX_W];

endmodule
`default_nettype wire

@@ design/gs3_outbuf.sv @@
`default_nettype none
module gs3_outbuf (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire gs3_pkg::t_res_item            i_item,
    output logic                               o_free,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [gs3_pkg::PIX_W-1:0]     o_pixel_out,
    output logic      [gs3_pkg::ROW_W-1:0]     o_out_row,
    output logic      [gs3_pkg::COL_OUT_W-1:0] o_out_col,
    output logic                               o_last
);
    import gs3_pkg::*;

    t_res_item  r_item;
    logic [2:0] r_pend;
    logic [2:0] low;
    logic [2:0] rest;
    logic       take;

    // lowest pending slot goes out first
    assign low  = r_pend & (~r_pend + 3'd1);
    assign rest = r_pend & ~low;
    assign take = o_valid & i_ready;

    assign o_valid = |r_pend;
    assign o_last  = (rest == 3'b000);
    assign o_free  = (r_pend == 3'b000) | (take & o_last);

    // pending slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_load) begin
            r_pend <= i_item.emit;
        end else if (take) begin
            r_pend <= rest;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    // result fields for the slot on show
    always_comb begin
        if (r_pend[EMIT_CTR]) begin
            o_pixel_out = r_item.smooth;
            o_out_row   = r_item.row - ROW_W'(1);
            o_out_col   = r_item.col - COL_OUT_W'(1);
        end else if (r_pend[EMIT_EDGE]) begin
            o_pixel_out = r_item.mid;
            o_out_row   = r_item.row - ROW_W'(1);
            o_out_col   = r_item.col;
        end else begin
            o_pixel_out = r_item.pix;
            o_out_row   = r_item.row;
            o_out_col   = r_item.col;
        end
    end

endmodule
`default_nettype wire

@@ design/gs3_checker.sv @@
`default_nettype none
module gs3_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_ready,
    input wire logic [gs3_pkg::PIX_W-1:0]     i_pixel_in,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic [gs3_pkg::PIX_W-1:0]     o_pixel_out,
    input wire logic [gs3_pkg::ROW_W-1:0]     o_out_row,
    input wire logic [gs3_pkg::COL_OUT_W-1:0] o_out_col,
    input wire logic                          o_last,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [gs3_pkg::APB_AW-1:0]    paddr,
    input wire logic [gs3_pkg::APB_DW-1:0]    pwdata,
    input wire logic [gs3_pkg::APB_DW-1:0]    prdata,
    input wire logic                          pready
);

    // an offered pixel waits unchanged until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_pixel_in))
        else $error("offered pixel dropped or changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_out) && $stable(o_out_row)
            && $stable(o_out_col) && $stable(o_last))
        else $error("stalled result changed");

    // the rest of an item's results follow without a gap
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid)
        else $error("item results broken up");

    // reset leaves nothing to deliver
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

    // frame_height reads back what was written
    a_height_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[2])
            ##1 (psel && !pwrite && paddr[2])
            |-> prdata[15:0] == $past(pwdata[15:0]))
        else $error("frame_height readback mismatch");

endmodule

bind gaussian_3x3_smooth_core gs3_checker u_gs3_checker (.*);
`default_nettype wire
